// ===== rtl/core/btmx_pkg.sv =====
// Package for the binary trie max-xor block: sizes, command codes and the
// request and result structs. No dependencies.
`timescale 1ns / 1ps

package btmx_pkg;

  localparam int KEY_BITS  = 32;
  localparam int NODE_POOL = 4096;
  localparam int NODE_W    = $clog2(NODE_POOL);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int ROW_W     = 2 * NODE_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
  } in_req_t;

  typedef struct packed {
    logic [31:0] max_xor;
    logic        found;
    logic        pool_full;
  } out_res_t;

  // row layout: child for bit 0 in the low half, child for bit 1 in the high half
  function automatic logic [NODE_W-1:0] child_of(input logic [ROW_W-1:0] row,
                                                 input logic bit_sel);
    logic [NODE_W-1:0] c;
    c = bit_sel ? row[ROW_W-1:NODE_W] : row[NODE_W-1:0];
    return c;
  endfunction

endpackage

// ===== rtl/core/btmx_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/binary_trie_max_xor.sv =====
// Binary trie with insert, find and maximum-xor query over 32-bit keys.
// Depends on btmx_pkg and btmx_ram (node table, one row of two links per node).
//
// Usage:
//   Requests enter on in_valid/in_stall/in_req (command and key); each request
//   gives exactly one result on out_valid/out_stall/out_res.
//   One request is worked on at a time; in_stall is high while busy.
//   The walk reads one node row per trie level through the node table's single
//   read port, one level a cycle, with an allocation step added on insert for
//   each new node. A find that misses or a query whose path runs out ends at
//   that level; a rejected insert or an unused command skips the walk and goes
//   straight to the result.
//   Each new node has its row cleared when allocated, so only the root row is
//   cleared after reset, during which in_stall is high.
//   The result sits in an output register; while out_stall holds it, the block
//   still accepts and works on the next request and waits only to hand over
//   its own result.
`timescale 1ns / 1ps

module binary_trie_max_xor
  import btmx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic              found_r, found_nxt;
  logic              full_r, full_nxt;
  logic              fresh_r, fresh_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_res_t          out_res_r, out_res_nxt;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [NODE_W-1:0] ram_raddr;
  logic [ROW_W-1:0]  ram_rdata;

  logic [ROW_W-1:0]  row;
  logic              kbit;
  logic [NODE_W-1:0] same_c;
  logic [NODE_W-1:0] opp_c;
  logic [NODE_W-1:0] step_c;

  btmx_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NODE_POOL)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // a freshly allocated node has no children, no read needed
  assign row    = fresh_r ? '0 : ram_rdata;
  assign kbit   = key_r[lvl_r];
  assign same_c = child_of(row, kbit);
  assign opp_c  = child_of(row, ~kbit);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    lvl_nxt       = lvl_r;
    acc_nxt       = acc_r;
    found_nxt     = found_r;
    full_nxt      = full_r;
    fresh_nxt     = fresh_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    step_c        = '0;

    case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        used_nxt  = CNT_W'(1);
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_req.cmd;
          key_nxt   = in_req.key;
          cur_nxt   = '0;
          lvl_nxt   = LVL_W'(KEY_BITS - 1);
          acc_nxt   = '0;
          found_nxt = 1'b0;
          full_nxt  = 1'b0;
          fresh_nxt = 1'b0;
          case (in_req.cmd)
            CMD_INSERT: begin
              if ((CNT_W'(NODE_POOL) - used_r) < CNT_W'(KEY_BITS)) begin
                full_nxt  = 1'b1;
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_WALK;
              end
            end
            CMD_FIND, CMD_QUERY: begin
              ram_re    = 1'b1;
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (same_c == '0) begin
              ram_we    = 1'b1;
              ram_waddr = cur_r;
              ram_wdata = kbit ? {used_r[NODE_W-1:0], row[NODE_W-1:0]}
                               : {row[ROW_W-1:NODE_W], used_r[NODE_W-1:0]};
              cur_nxt   = used_r[NODE_W-1:0];
              used_nxt  = used_r + CNT_W'(1);
              state_nxt = S_ALLOC;
            end else begin
              step_c = same_c;
            end
          end
          CMD_FIND: begin
            step_c = same_c;
            if (same_c == '0) begin
              state_nxt = S_DONE;
            end else if (lvl_r == '0) begin
              found_nxt = 1'b1;
            end
          end
          CMD_QUERY: begin
            if (opp_c != '0) begin
              acc_nxt = {acc_r[30:0], 1'b1};
              step_c  = opp_c;
            end else if (same_c != '0) begin
              acc_nxt = {acc_r[30:0], 1'b0};
              step_c  = same_c;
            end else begin
              state_nxt = S_DONE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
        if (step_c != '0) begin
          if (lvl_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = step_c;
            cur_nxt   = step_c;
            lvl_nxt   = lvl_r - LVL_W'(1);
          end
        end
      end

      S_ALLOC: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r;
        ram_wdata = '0;
        if (lvl_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          lvl_nxt   = lvl_r - LVL_W'(1);
          fresh_nxt = 1'b1;
          state_nxt = S_WALK;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_res_nxt.max_xor   = acc_r;
          out_res_nxt.found     = found_r;
          out_res_nxt.pool_full = full_r;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      used_r      <= CNT_W'(1);
      out_valid_r <= 1'b0;
      fresh_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      fresh_r     <= fresh_nxt;
    end
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    cur_r     <= cur_nxt;
    lvl_r     <= lvl_nxt;
    acc_r     <= acc_nxt;
    found_r   <= found_nxt;
    full_r    <= full_nxt;
    out_res_r <= out_res_nxt;
  end

  // an accepted request always makes the block busy in the cycle after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block idle right after accepting a request");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(NODE_POOL))
    else $error("node pool overrun");

  a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (cmd_r == CMD_INSERT) || (state_r == S_INIT))
    else $error("node table written outside insert");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.found && out_res_r.pool_full))
    else $error("found and pool_full both set");

  a_alloc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ALLOC |-> used_r == $past(used_r) + CNT_W'(1))
    else $error("allocation did not advance node count");

endmodule

// ===== tb/binary_trie_max_xor_test.sv =====
// Self-checking testbench for binary_trie_max_xor: a directed table, then random insert,
// find, query, unused requests; results checked against typed rows or a trie predictor.
// Depends on btmx_pkg and the binary_trie_max_xor RTL.
`timescale 1ns / 1ps

module binary_trie_max_xor_test;
  import btmx_pkg::*;

  localparam int RANDOM_ITEMS = 1600;
  localparam int PAUSE_AT     = 800;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_res_t res;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_req = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_res_t out_res;

  logic [NODE_W-1:0] trie_link [0:2*NODE_POOL-1];
  int unsigned       nodes_in_use;
  logic [31:0]       stored_keys [$];
  out_res_t          pending_res [$];
  stim_row_t         stim_rows [$];
  out_res_t          want;

  int mismatch_count = 0;
  int results_checked = 0;
  int n_insert = 0, n_refused = 0, n_find = 0, n_hit = 0, n_query = 0, n_unused = 0;
  int stall_hold = 0;
  int stall_cycle = 0;

  binary_trie_max_xor u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("binary_trie_max_xor test failed");
    $finish;
  end

  function automatic out_res_t trie_response(input in_req_t r);
    out_res_t    res;
    int unsigned cur;
    int unsigned nxt;
    int unsigned opp;
    int          lvl;
    logic        b;
    logic        walking;
    res = '0;
    cur = 0;
    walking = 1'b1;
    case (r.cmd)
      CMD_INSERT: begin
        if (NODE_POOL - nodes_in_use < KEY_BITS) begin
          res.pool_full = 1'b1;
        end else begin
          for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
            b = r.key[lvl];
            nxt = trie_link[2*cur + b];
            if (nxt == 0) begin
              nxt = nodes_in_use;
              nodes_in_use++;
              trie_link[2*cur + b] = NODE_W'(nxt);
            end
            cur = nxt;
          end
          stored_keys.push_back(r.key);
        end
      end
      CMD_FIND: begin
        res.found = 1'b1;
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          if (res.found) begin
            nxt = trie_link[2*cur + r.key[lvl]];
            if (nxt == 0) res.found = 1'b0;
            else cur = nxt;
          end
        end
      end
      CMD_QUERY: begin
        for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
          if (walking) begin
            b = r.key[lvl];
            opp = trie_link[2*cur + !b];
            nxt = trie_link[2*cur + b];
            if (opp != 0) begin
              res.max_xor = {res.max_xor[30:0], 1'b1};
              cur = opp;
            end else if (nxt != 0) begin
              res.max_xor = {res.max_xor[30:0], 1'b0};
              cur = nxt;
            end else begin
              walking = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // shared prefixes and small values keep the pool alive longer and the walks deep
  function automatic logic [31:0] fresh_key();
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: return $urandom_range(0, 1023);
      default: return {8'hC3, 24'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] known_key();
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    int      pick;
    int      how;
    pick = $urandom_range(0, 99);
    how = $urandom_range(0, 4);
    r.key = fresh_key();
    if (pick < 30) begin
      r.cmd = CMD_INSERT;
      if (how == 0 && stored_keys.size() > 0) r.key = known_key();
    end else if (pick < 63) begin
      r.cmd = CMD_FIND;
      if (how < 3 && stored_keys.size() > 0) r.key = known_key();
      if (how == 2) r.key = r.key ^ (32'h1 << $urandom_range(0, 31));
    end else if (pick < 96) begin
      r.cmd = CMD_QUERY;
      if (how == 0 && stored_keys.size() > 0) r.key = known_key();
    end else begin
      r.cmd = CMD_NONE;
      r.key = $urandom;
    end
    return r;
  endfunction

  task automatic add_row(input cmd_t c, input logic [31:0] k, input bit typed,
                         input logic [31:0] x, input bit f, input bit p);
    stim_row_t row;
    row.req.cmd = c;
    row.req.key = k;
    row.typed = typed;
    row.res.max_xor = x;
    row.res.found = f;
    row.res.pool_full = p;
    stim_rows.push_back(row);
  endtask

  task automatic send_req(input in_req_t r, input bit typed, input out_res_t typed_res);
    out_res_t res;
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = trie_response(r);
    pending_res.push_back(typed ? typed_res : res);
    case (r.cmd)
      CMD_INSERT: begin
        n_insert++;
        n_refused += res.pool_full;
      end
      CMD_FIND: begin
        n_find++;
        n_hit += res.found;
      end
      CMD_QUERY: n_query++;
      default: n_unused++;
    endcase
  endtask

  always @(posedge clk) begin
    stall_cycle++;
    if ((stall_cycle / 600) % 3 == 1) begin
      out_stall <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: max_xor %h found %b pool_full %b",
                   out_res.max_xor, out_res.found, out_res.pool_full);
      end else begin
        want = pending_res.pop_front();
        if (out_res.max_xor !== want.max_xor || out_res.found !== want.found ||
            out_res.pool_full !== want.pool_full) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: want max_xor %h found %b pool_full %b, got %h %b %b",
                     results_checked, want.max_xor, want.found, want.pool_full,
                     out_res.max_xor, out_res.found, out_res.pool_full);
        end
        results_checked++;
      end
    end
  end

  initial begin
    int total;
    int gap;
    int waited;
    bit hold;
    foreach (trie_link[i]) trie_link[i] = '0;
    nodes_in_use = 1;

    add_row(CMD_QUERY,  32'h0000_0000, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_FIND,   32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_NONE,   32'hDEAD_BEEF, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_INSERT, 32'h0000_0000, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_QUERY,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 0);
    add_row(CMD_FIND,   32'h0000_0000, 1, 32'h0000_0000, 1, 0);
    add_row(CMD_FIND,   32'h0000_0001, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_INSERT, 32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_QUERY,  32'h0000_0000, 1, 32'hFFFF_FFFF, 0, 0);
    add_row(CMD_QUERY,  32'h0000_FFFF, 0, '0, 0, 0);
    add_row(CMD_INSERT, 32'h0000_0000, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_INSERT, 32'h8000_0000, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_QUERY,  32'h7FFF_FFFF, 0, '0, 0, 0);
    add_row(CMD_FIND,   32'h8000_0000, 1, 32'h0000_0000, 1, 0);
    add_row(CMD_FIND,   32'h8000_0001, 0, '0, 0, 0);
    add_row(CMD_NONE,   32'hFFFF_FFFF, 1, 32'h0000_0000, 0, 0);
    add_row(CMD_INSERT, 32'h5555_5555, 0, '0, 0, 0);
    add_row(CMD_INSERT, 32'hAAAA_AAAA, 0, '0, 0, 0);
    add_row(CMD_QUERY,  32'h1234_5678, 0, '0, 0, 0);
    add_row(CMD_QUERY,  32'hAAAA_AAAA, 0, '0, 0, 0);
    add_row(CMD_FIND,   32'hAAAA_AAAA, 0, '0, 0, 0);
    add_row(CMD_FIND,   32'h0555_5555, 0, '0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    total = stim_rows.size() + RANDOM_ITEMS;
    for (int i = 0; i < total; i++) begin
      if (i < stim_rows.size())
        send_req(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].res);
      else
        send_req(random_req(), 1'b0, '0);
      gap = ((i / 150) % 4 == 2) ? 0 : idle_len();
      hold = (i == stim_rows.size() + PAUSE_AT);
      if (gap > 0 || hold) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        // hold off until the block has handed back everything in flight
        while (hold && pending_res.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending_res.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (80) @(posedge clk);

    if (pending_res.size() != 0) begin
      $display("%0d results never arrived", pending_res.size());
      mismatch_count++;
    end
    $display("covered %0d requests: %0d inserts (%0d refused, pool full), %0d finds (%0d hits)",
             total, n_insert, n_refused, n_find, n_hit);
    $display("%0d queries, %0d unused commands; %0d results compared, %0d mismatches",
             n_query, n_unused, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("binary_trie_max_xor test passed");
    end else begin
      $display("binary_trie_max_xor test failed");
    end
    $finish;
  end

endmodule
